// ===== rtl/lob_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;
    localparam int ORDER_SLOTS_DEF = 32;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_EXEC   = 2'd2;
    localparam logic [1:0] CMD_MARKET = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_BADQTY  = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic        is_fill;
        logic [31:0] fill_order_id;
        logic [31:0] fill_qty;
        logic [31:0] executed_total;
        logic [31:0] best_bid;
        logic        bid_present;
        logic [31:0] best_ask;
        logic        ask_present;
        logic [5:0]  order_count;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

// ===== rtl/lob_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared compare unit: decides whether the candidate slot beats the current best.
module lob_cmp (
    input  wire logic        sell,
    input  wire logic        have_best,
    input  wire logic [31:0] cand_price,
    input  wire logic [31:0] best_price,
    input  wire logic [31:0] cand_age,
    input  wire logic [31:0] best_age,
    output logic             better
);
    always_comb begin
        if (!have_best) begin
            better = 1'b1;
        end else if (cand_price != best_price) begin
            better = sell ? (cand_price < best_price) : (cand_price > best_price);
        end else begin
            better = cand_age > best_age;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/limit_order_book_engine_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Single-instrument limit order book with price-time priority.
// One command item enters on the s_ channel (cmd, side, order_id, price,
// quantity). Results leave on the m_ channel; the final result of each item
// has m_last set. A market command first gives one fill record per resting
// order it touches, then the completion.
// The block serves one item at a time. One sequencer walks the slots, one
// slot per cycle, with a single compare unit. An add, cancel or execute
// scans the slots for the id, applies the change, then scans for the best
// bid, then for the best ask, and loads the completion. A market command
// skips the id scan; for each fill record it scans the opposite side for
// the best order and then writes the fill, and it makes one more empty
// scan when the opposite side runs dry.
// Reset (aresetn low, synchronous) empties the book and clears the arrival
// counter. When the receiver holds m_ready low the result stays in the
// output register and the sequencer waits at its next result. s_ready goes
// high as soon as the completion is in the output register.
module limit_order_book_engine_unit #(
    parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic        s_side,
    input  wire logic [31:0] s_order_id,
    input  wire logic [31:0] s_price,
    input  wire logic [31:0] s_quantity,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic             m_is_fill,
    output logic [31:0]      m_fill_order_id,
    output logic [31:0]      m_fill_qty,
    output logic [31:0]      m_executed_total,
    output logic [31:0]      m_best_bid,
    output logic             m_bid_present,
    output logic [31:0]      m_best_ask,
    output logic             m_ask_present,
    output logic [5:0]       m_order_count,
    output logic             m_last
);
    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_IDSC  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_BEST  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;
    localparam logic [2:0] S_BOOK  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic                   side_mem   [ORDER_SLOTS];
    logic [31:0]            id_mem     [ORDER_SLOTS];
    logic [31:0]            price_mem  [ORDER_SLOTS];
    logic [31:0]            rem_mem    [ORDER_SLOTS];
    logic [31:0]            arr_mem    [ORDER_SLOTS];

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic        side_reg, side_next;
    logic [31:0] oid_reg, oid_next;
    logic [31:0] prc_reg, prc_next;
    logic [31:0] qty_reg, qty_next;
    logic [31:0] arrival_reg, arrival_next;
    logic [5:0]  count_reg, count_next;
    logic        found_reg, found_next;
    logic [IW-1:0] hit_reg, hit_next;
    logic        free_ok_reg, free_ok_next;
    logic [IW-1:0] free_reg, free_next;
    logic        have_reg, have_next;
    logic [IW-1:0] best_reg, best_next;
    logic [31:0] bprice_reg, bprice_next;
    logic [31:0] bage_reg, bage_next;
    logic        book_side_reg, book_side_next;
    logic [31:0] total_reg, total_next;
    logic [2:0]  status_reg, status_next;
    logic [31:0] bid_reg, bid_next;
    logic        bid_ok_reg, bid_ok_next;
    logic [31:0] ask_reg, ask_next;
    logic        ask_ok_reg, ask_ok_next;
    logic        mv_reg, mv_next;
    lob_pkg::result_t res_reg, res_next;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic          wr_side;
    logic [31:0]   wr_id, wr_price, wr_rem, wr_arr;
    logic          rem_en;
    logic [31:0]   rem_val;

    logic [IW-1:0] ix;
    logic          cand_ok, better;
    logic [31:0]   cand_age;
    logic [31:0]   brem, fqty;

    assign ix = idx_reg[IW-1:0];
    assign cand_age = arrival_reg - arr_mem[ix];
    assign cand_ok = valid_reg[ix] && (side_mem[ix] == book_side_reg);
    assign brem = rem_mem[best_reg];
    assign fqty = (qty_reg < brem) ? qty_reg : brem;

    lob_cmp u_cmp (
        .sell       (book_side_reg),
        .have_best  (have_reg),
        .cand_price (price_mem[ix]),
        .best_price (bprice_reg),
        .cand_age   (cand_age),
        .best_age   (bage_reg),
        .better     (better)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            side_mem[wr_idx]  <= wr_side;
            id_mem[wr_idx]    <= wr_id;
            price_mem[wr_idx] <= wr_price;
            arr_mem[wr_idx]   <= wr_arr;
        end
        if (rem_en) begin
            rem_mem[wr_idx] <= rem_val;
        end
    end

    always_comb begin
        state_next = state_reg;  idx_next = idx_reg;
        cmd_next = cmd_reg;  side_next = side_reg;  oid_next = oid_reg;
        prc_next = prc_reg;  qty_next = qty_reg;
        arrival_next = arrival_reg;  count_next = count_reg;
        valid_next = valid_reg;
        found_next = found_reg;  hit_next = hit_reg;
        free_ok_next = free_ok_reg;  free_next = free_reg;
        have_next = have_reg;  best_next = best_reg;
        bprice_next = bprice_reg;  bage_next = bage_reg;
        book_side_next = book_side_reg;
        total_next = total_reg;  status_next = status_reg;
        bid_next = bid_reg;  bid_ok_next = bid_ok_reg;
        ask_next = ask_reg;  ask_ok_next = ask_ok_reg;
        mv_next = mv_reg;  res_next = res_reg;
        wr_en = 1'b0;  rem_en = 1'b0;  wr_idx = hit_reg;
        wr_side = side_reg;  wr_id = oid_reg;  wr_price = prc_reg;
        wr_arr = arrival_reg;  rem_val = qty_reg;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next = s_cmd;  side_next = s_side;  oid_next = s_order_id;
                    prc_next = s_price;  qty_next = s_quantity;
                    idx_next = '0;  found_next = 1'b0;  free_ok_next = 1'b0;
                    total_next = '0;  status_next = lob_pkg::ST_OK;
                    if (s_cmd == lob_pkg::CMD_MARKET) begin
                        book_side_next = ~s_side;  have_next = 1'b0;
                        state_next = (s_quantity == '0) ? S_BOOK : S_BEST;
                        if (s_quantity == '0) begin
                            book_side_next = 1'b0;
                        end
                    end else begin
                        state_next = S_IDSC;
                    end
                end
            end
            S_IDSC: begin
                if (valid_reg[ix] && id_mem[ix] == oid_reg && !found_reg) begin
                    found_next = 1'b1;  hit_next = ix;
                end
                if (!valid_reg[ix] && !free_ok_reg) begin
                    free_ok_next = 1'b1;  free_next = ix;
                end
                if (idx_reg == CW'(ORDER_SLOTS - 1)) begin
                    state_next = S_APPLY;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_APPLY: begin
                case (cmd_reg)
                    lob_pkg::CMD_ADD: begin
                        if (qty_reg == '0) begin
                            status_next = lob_pkg::ST_BADQTY;
                        end else if (found_reg) begin
                            status_next = lob_pkg::ST_DUP;
                        end else if (!free_ok_reg) begin
                            status_next = lob_pkg::ST_FULL;
                        end else begin
                            wr_en = 1'b1;  rem_en = 1'b1;  wr_idx = free_reg;
                            valid_next[free_reg] = 1'b1;
                            arrival_next = arrival_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    lob_pkg::CMD_CANCEL: begin
                        if (!found_reg) begin
                            status_next = lob_pkg::ST_UNKNOWN;
                        end else begin
                            valid_next[hit_reg] = 1'b0;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    default: begin
                        if (!found_reg) begin
                            status_next = lob_pkg::ST_UNKNOWN;
                        end else if (qty_reg == '0 || qty_reg > rem_mem[hit_reg]) begin
                            status_next = lob_pkg::ST_BADQTY;
                        end else begin
                            rem_en = 1'b1;
                            rem_val = rem_mem[hit_reg] - qty_reg;
                            if (rem_val == '0) begin
                                valid_next[hit_reg] = 1'b0;
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                endcase
                state_next = S_BOOK;  book_side_next = 1'b0;
                have_next = 1'b0;  idx_next = '0;
            end
            S_BEST: begin
                if (cand_ok && better) begin
                    have_next = 1'b1;  best_next = ix;
                    bprice_next = price_mem[ix];  bage_next = cand_age;
                end
                if (idx_reg == CW'(ORDER_SLOTS - 1)) begin
                    idx_next = '0;
                    if (cand_ok && better) begin
                        state_next = S_FILL;
                    end else if (have_reg) begin
                        state_next = S_FILL;
                    end else begin
                        state_next = S_BOOK;  book_side_next = 1'b0;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FILL: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    res_next = '0;
                    res_next.is_fill = 1'b1;
                    res_next.fill_order_id = id_mem[best_reg];
                    res_next.fill_qty = fqty;
                    rem_en = 1'b1;  wr_idx = best_reg;  rem_val = brem - fqty;
                    if (brem == fqty) begin
                        valid_next[best_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                    end
                    total_next = total_reg + fqty;
                    qty_next = qty_reg - fqty;
                    have_next = 1'b0;  idx_next = '0;
                    if (qty_reg == fqty) begin
                        state_next = S_BOOK;  book_side_next = 1'b0;
                    end else begin
                        state_next = S_BEST;
                    end
                end
            end
            S_BOOK: begin
                if (cand_ok && better) begin
                    have_next = 1'b1;  bprice_next = price_mem[ix];
                    bage_next = cand_age;
                end
                if (idx_reg == CW'(ORDER_SLOTS - 1)) begin
                    idx_next = '0;
                    if (!book_side_reg) begin
                        bid_next = (cand_ok && better) ? price_mem[ix] :
                                   (have_reg ? bprice_reg : '0);
                        bid_ok_next = have_reg || (cand_ok && better);
                        book_side_next = 1'b1;  have_next = 1'b0;
                    end else begin
                        ask_next = (cand_ok && better) ? price_mem[ix] :
                                   (have_reg ? bprice_reg : '0);
                        ask_ok_next = have_reg || (cand_ok && better);
                        state_next = S_OUT;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    res_next.status = status_reg;
                    res_next.is_fill = 1'b0;
                    res_next.fill_order_id = '0;
                    res_next.fill_qty = '0;
                    res_next.executed_total = total_reg;
                    res_next.best_bid = bid_reg;
                    res_next.bid_present = bid_ok_reg;
                    res_next.best_ask = ask_reg;
                    res_next.ask_present = ask_ok_reg;
                    res_next.order_count = count_reg;
                    res_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;  valid_reg <= '0;  arrival_reg <= '0;
            count_reg <= '0;  mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;  valid_reg <= valid_next;
            arrival_reg <= arrival_next;  count_reg <= count_next;
            mv_reg <= mv_next;
        end
        idx_reg <= idx_next;  cmd_reg <= cmd_next;  side_reg <= side_next;
        oid_reg <= oid_next;  prc_reg <= prc_next;  qty_reg <= qty_next;
        found_reg <= found_next;  hit_reg <= hit_next;
        free_ok_reg <= free_ok_next;  free_reg <= free_next;
        have_reg <= have_next;  best_reg <= best_next;
        bprice_reg <= bprice_next;  bage_reg <= bage_next;
        book_side_reg <= book_side_next;  total_reg <= total_next;
        status_reg <= status_next;  res_reg <= res_next;
        bid_reg <= bid_next;  bid_ok_reg <= bid_ok_next;
        ask_reg <= ask_next;  ask_ok_reg <= ask_ok_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = mv_reg;
    assign m_status         = res_reg.status;
    assign m_is_fill        = res_reg.is_fill;
    assign m_fill_order_id  = res_reg.fill_order_id;
    assign m_fill_qty       = res_reg.fill_qty;
    assign m_executed_total = res_reg.executed_total;
    assign m_best_bid       = res_reg.best_bid;
    assign m_bid_present    = res_reg.bid_present;
    assign m_best_ask       = res_reg.best_ask;
    assign m_ask_present    = res_reg.ask_present;
    assign m_order_count    = res_reg.order_count;
    assign m_last           = res_reg.last;
endmodule
`default_nettype wire

// ===== sim/lob_book_checker.sv =====
`timescale 1ns / 1ps
module lob_book_checker #(
    parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_side,
    input  logic [31:0] s_order_id,
    input  logic [31:0] s_price,
    input  logic [31:0] s_quantity,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic        m_is_fill,
    input  logic [31:0] m_fill_order_id,
    input  logic [31:0] m_fill_qty,
    input  logic [31:0] m_executed_total,
    input  logic [31:0] m_best_bid,
    input  logic        m_bid_present,
    input  logic [31:0] m_best_ask,
    input  logic        m_ask_present,
    input  logic [5:0]  m_order_count,
    input  logic        m_last,
    output int          fail_count,
    output int          pending
);
    bit          book_used [ORDER_SLOTS];
    bit          book_side [ORDER_SLOTS];
    logic [31:0] book_id [ORDER_SLOTS];
    logic [31:0] book_price [ORDER_SLOTS];
    logic [31:0] book_left [ORDER_SLOTS];
    logic [31:0] book_stamp [ORDER_SLOTS];
    logic [31:0] stamp_now;
    logic [5:0]  resting;
    lob_pkg::result_t expected_results[$];

    function automatic int find_order(logic [31:0] id);
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            if (book_used[i] && book_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Highest bid or lowest ask; among equal prices the oldest order wins.
    function automatic int top_of_side(bit sd);
        int pick;
        logic [31:0] age_i, age_p;
        pick = -1;
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            if (!book_used[i] || book_side[i] != sd) continue;
            if (pick < 0) begin
                pick = i;
            end else if (book_price[i] != book_price[pick]) begin
                if (sd == 1'b0 ? book_price[i] > book_price[pick]
                               : book_price[i] < book_price[pick]) pick = i;
            end else begin
                age_i = stamp_now - book_stamp[i];
                age_p = stamp_now - book_stamp[pick];
                if (age_i > age_p) pick = i;
            end
        end
        return pick;
    endfunction

    function automatic lob_pkg::result_t completion(logic [2:0] st, logic [31:0] total);
        lob_pkg::result_t r;
        int b, a;
        r = '0;
        r.status = st;
        r.executed_total = total;
        b = top_of_side(1'b0);
        a = top_of_side(1'b1);
        if (b >= 0) begin
            r.best_bid = book_price[b];
            r.bid_present = 1'b1;
        end
        if (a >= 0) begin
            r.best_ask = book_price[a];
            r.ask_present = 1'b1;
        end
        r.order_count = resting;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void remove_order(int i);
        book_used[i] = 1'b0;
        if (resting != 0) resting--;
    endfunction

    function automatic void run_command(logic [1:0] c, bit sd, logic [31:0] id,
                                        logic [31:0] pr, logic [31:0] q);
        logic [2:0]  st;
        logic [31:0] total, left, take;
        lob_pkg::result_t f;
        int          i;
        st = lob_pkg::ST_OK;
        total = '0;
        case (c)
            lob_pkg::CMD_ADD: begin
                if (q == 0) st = lob_pkg::ST_BADQTY;
                else if (find_order(id) >= 0) st = lob_pkg::ST_DUP;
                else if (resting >= ORDER_SLOTS) st = lob_pkg::ST_FULL;
                else begin
                    for (i = 0; i < ORDER_SLOTS; i++) if (!book_used[i]) break;
                    book_used[i] = 1'b1;
                    book_side[i] = sd;
                    book_id[i] = id;
                    book_price[i] = pr;
                    book_left[i] = q;
                    book_stamp[i] = stamp_now;
                    stamp_now++;
                    resting++;
                end
            end
            lob_pkg::CMD_CANCEL: begin
                i = find_order(id);
                if (i < 0) st = lob_pkg::ST_UNKNOWN;
                else remove_order(i);
            end
            lob_pkg::CMD_EXEC: begin
                i = find_order(id);
                if (i < 0) st = lob_pkg::ST_UNKNOWN;
                else if (q == 0 || q > book_left[i]) st = lob_pkg::ST_BADQTY;
                else begin
                    book_left[i] -= q;
                    if (book_left[i] == 0) remove_order(i);
                end
            end
            lob_pkg::CMD_MARKET: begin
                left = q;
                while (left != 0) begin
                    i = top_of_side(~sd);
                    if (i < 0) break;
                    take = (left < book_left[i]) ? left : book_left[i];
                    f = '0;
                    f.is_fill = 1'b1;
                    f.fill_order_id = book_id[i];
                    f.fill_qty = take;
                    expected_results.insert(expected_results.size(), f);
                    left -= take;
                    total += take;
                    book_left[i] -= take;
                    if (book_left[i] == 0) remove_order(i);
                end
            end
            default: ;
        endcase
        expected_results.insert(expected_results.size(), completion(st, total));
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        lob_pkg::result_t e;
        if (!aresetn) begin
            for (int i = 0; i < ORDER_SLOTS; i++) book_used[i] = 1'b0;
            stamp_now = '0;
            resting = '0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready)
                run_command(s_cmd, s_side, s_order_id, s_price, s_quantity);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", e.status, m_status);
                    check_field("is_fill", e.is_fill, m_is_fill);
                    check_field("fill_order_id", e.fill_order_id, m_fill_order_id);
                    check_field("fill_qty", e.fill_qty, m_fill_qty);
                    check_field("executed_total", e.executed_total, m_executed_total);
                    check_field("best_bid", e.best_bid, m_best_bid);
                    check_field("bid_present", e.bid_present, m_bid_present);
                    check_field("best_ask", e.best_ask, m_best_ask);
                    check_field("ask_present", e.ask_present, m_ask_present);
                    check_field("order_count", e.order_count, m_order_count);
                    check_field("last", e.last, m_last);
                end
            end
        end
        pending = expected_results.size();
    end
endmodule

// ===== sim/limit_order_book_engine_unit_tb.sv =====
`timescale 1ns / 1ps
module limit_order_book_engine_unit_tb;
    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic        s_side;
    logic [31:0] s_order_id;
    logic [31:0] s_price;
    logic [31:0] s_quantity;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic        m_is_fill;
    logic [31:0] m_fill_order_id;
    logic [31:0] m_fill_qty;
    logic [31:0] m_executed_total;
    logic [31:0] m_best_bid;
    logic        m_bid_present;
    logic [31:0] m_best_ask;
    logic        m_ask_present;
    logic [5:0]  m_order_count;
    logic        m_last;
    int          fail_count;
    int          pending;
    bit          quiet;

    limit_order_book_engine_unit i_dut (.*);

    lob_book_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(logic [1:0] c, bit sd, logic [31:0] id,
                            logic [31:0] pr, logic [31:0] q);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c;
        s_side <= sd;
        s_order_id <= id;
        s_price <= pr;
        s_quantity <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 39);
        if (r < 95) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_price();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 1000 + $urandom_range(0, 7);
        if (r < 95) return $urandom;
        return (r < 97) ? 32'd0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [31:0] pick_qty(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(1, span);
        if (r < 94) return 0;
        if (r < 98) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    initial begin
        int r;
        quiet = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = lob_pkg::CMD_ADD;
        s_side = 1'b0;
        s_order_id = '0;
        s_price = '0;
        s_quantity = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_cmd(lob_pkg::CMD_ADD, 1'b0, 32'd5, 32'd100, 32'd0);
        send_cmd(lob_pkg::CMD_ADD, 1'b0, 32'd0, 32'd0, 32'd1);
        send_cmd(lob_pkg::CMD_ADD, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(lob_pkg::CMD_ADD, 1'b1, 32'd0, 32'd50, 32'd3);
        send_cmd(lob_pkg::CMD_CANCEL, 1'b0, 32'd77, 32'd0, 32'd0);
        send_cmd(lob_pkg::CMD_EXEC, 1'b0, 32'd77, 32'd0, 32'd1);
        send_cmd(lob_pkg::CMD_EXEC, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_cmd(lob_pkg::CMD_EXEC, 1'b0, 32'd0, 32'd0, 32'd2);
        send_cmd(lob_pkg::CMD_EXEC, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFE);
        send_cmd(lob_pkg::CMD_EXEC, 1'b0, 32'd0, 32'd0, 32'd1);
        send_cmd(lob_pkg::CMD_CANCEL, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_cmd(lob_pkg::CMD_MARKET, 1'b1, 32'd0, 32'd0, 32'd0);
        send_cmd(lob_pkg::CMD_MARKET, 1'b1, 32'd0, 32'd0, 32'd10);
        send_cmd(lob_pkg::CMD_ADD, 1'b1, 32'd10, 32'd200, 32'd4);
        send_cmd(lob_pkg::CMD_ADD, 1'b1, 32'd11, 32'd200, 32'd5);
        send_cmd(lob_pkg::CMD_ADD, 1'b1, 32'd12, 32'd199, 32'd6);
        send_cmd(lob_pkg::CMD_ADD, 1'b1, 32'd13, 32'd201, 32'd7);
        send_cmd(lob_pkg::CMD_MARKET, 1'b0, 32'd0, 32'd0, 32'd12);
        send_cmd(lob_pkg::CMD_MARKET, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Fill every slot, then one more add must find the book full.
        for (int k = 0; k < 33; k++)
            send_cmd(lob_pkg::CMD_ADD, k[0], 32'd100 + k, 32'd300 + (k % 4), 32'd2);
        send_cmd(lob_pkg::CMD_MARKET, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_cmd(lob_pkg::CMD_MARKET, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);

        for (int k = 0; k < 115; k++) begin
            if (k == 95) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45)
                send_cmd(lob_pkg::CMD_ADD, $urandom_range(0, 1), pick_id(), pick_price(),
                         pick_qty(50));
            else if (r < 60)
                send_cmd(lob_pkg::CMD_CANCEL, $urandom_range(0, 1), pick_id(), $urandom,
                         $urandom);
            else if (r < 80)
                send_cmd(lob_pkg::CMD_EXEC, $urandom_range(0, 1), pick_id(), $urandom,
                         pick_qty(30));
            else
                send_cmd(lob_pkg::CMD_MARKET, $urandom_range(0, 1), $urandom, $urandom,
                         pick_qty(100));
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
